>>> sv/utf8_pkg.sv
// Package for the UTF-8 stream decoder.
// Holds the field widths, the error codes and the range limits.
// No dependencies.
package utf8_pkg;

	localparam int BYTE_W = 8;
	localparam int CP_W   = 21;
	localparam int LEN_W  = 3;
	localparam int PEND_W = 2;

	// Error codes carried with each result item.
	typedef enum logic [2:0] {
		ERR_NONE       = 3'd0,
		ERR_BAD_LEAD   = 3'd1,
		ERR_BAD_CONT   = 3'd2,
		ERR_OVERLONG   = 3'd3,
		ERR_SURROGATE  = 3'd4,
		ERR_ABOVE_MAX  = 3'd5
	} utf8_err_t;

	// Smallest legal value for each multi-byte sequence length, and range limits.
	localparam logic [CP_W-1:0] MIN_TWO_BYTE   = 21'h00080;
	localparam logic [CP_W-1:0] MIN_THREE_BYTE = 21'h00800;
	localparam logic [CP_W-1:0] MIN_FOUR_BYTE  = 21'h10000;
	localparam logic [CP_W-1:0] SURR_LOW       = 21'h0D800;
	localparam logic [CP_W-1:0] SURR_HIGH      = 21'h0DFFF;
	localparam logic [CP_W-1:0] CP_MAX         = 21'h10FFFF;

endpackage

>>> sv/utf8_stream_decoder_top.sv
// UTF-8 stream decoder: one byte per item in, one code point or error out.
// A byte waits in the input register until the result register is free or draining.
// Throughput: one byte per cycle while the output is not stalled; the only loop is the state update.
// Reset: arst_n clears the sequence state and both valid flags at once.
// Depends on utf8_pkg.
module utf8_stream_decoder_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [utf8_pkg::BYTE_W-1:0]   in_byte,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [utf8_pkg::CP_W-1:0]     code_point,
	output logic [utf8_pkg::LEN_W-1:0]    seq_length,
	output logic [2:0]                    error_kind
);
	import utf8_pkg::*;

	logic                valid_s1;
	logic [BYTE_W-1:0]   byte_s1;
	logic                advance;

	logic [PEND_W-1:0]   pending_q, pending_d;
	logic [CP_W-1:0]     gathered_q, gathered_d;
	logic [LEN_W-1:0]    total_q, total_d;

	logic                res_valid;
	logic [CP_W-1:0]     res_cp;
	logic [LEN_W-1:0]    res_len;
	utf8_err_t           res_err;
	logic [CP_W-1:0]     shifted;

	logic                out_valid_q;
	logic [CP_W-1:0]     code_point_q;
	logic [LEN_W-1:0]    seq_length_q;
	utf8_err_t           error_kind_q;

	// The staged byte moves on when the result register is free or draining.
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= in_byte;
		end
	end

	// Decode one byte against the sequence state.
	assign shifted = {gathered_q[CP_W-7:0], byte_s1[5:0]};

	always_comb begin
		pending_d  = pending_q;
		gathered_d = gathered_q;
		total_d    = total_q;
		res_valid  = 1'b0;
		res_cp     = '0;
		res_len    = LEN_W'(1);
		res_err    = ERR_NONE;
		if (pending_q == '0) begin
			if (!byte_s1[7]) begin
				res_valid = 1'b1;
				res_cp    = CP_W'(byte_s1);
			end else if (byte_s1[7:5] == 3'b110) begin
				gathered_d = CP_W'(byte_s1[4:0]);
				pending_d  = PEND_W'(1);
				total_d    = LEN_W'(2);
			end else if (byte_s1[7:4] == 4'b1110) begin
				gathered_d = CP_W'(byte_s1[3:0]);
				pending_d  = PEND_W'(2);
				total_d    = LEN_W'(3);
			end else if (byte_s1[7:3] == 5'b11110) begin
				gathered_d = CP_W'(byte_s1[2:0]);
				pending_d  = PEND_W'(3);
				total_d    = LEN_W'(4);
			end else begin
				res_valid = 1'b1;
				res_err   = ERR_BAD_LEAD;
			end
		end else if (byte_s1[7:6] != 2'b10) begin
			// Broken sequence: report what was taken, drop this byte.
			res_valid  = 1'b1;
			res_err    = ERR_BAD_CONT;
			res_len    = total_q - LEN_W'(pending_q) + LEN_W'(1);
			pending_d  = '0;
			gathered_d = '0;
			total_d    = '0;
		end else if (pending_q != PEND_W'(1)) begin
			gathered_d = shifted;
			pending_d  = pending_q - PEND_W'(1);
		end else begin
			// Last continuation byte: range checks on the completed value.
			res_valid  = 1'b1;
			res_len    = total_q;
			if (total_q == LEN_W'(2)) begin
				if (shifted < MIN_TWO_BYTE) res_err = ERR_OVERLONG;
			end else if (total_q == LEN_W'(3)) begin
				if (shifted < MIN_THREE_BYTE) begin
					res_err = ERR_OVERLONG;
				end else if (shifted >= SURR_LOW && shifted <= SURR_HIGH) begin
					res_err = ERR_SURROGATE;
				end
			end else begin
				if (shifted < MIN_FOUR_BYTE) begin
					res_err = ERR_OVERLONG;
				end else if (shifted > CP_MAX) begin
					res_err = ERR_ABOVE_MAX;
				end
			end
			res_cp     = (res_err == ERR_NONE) ? shifted : '0;
			pending_d  = '0;
			gathered_d = '0;
			total_d    = '0;
		end
	end

	// Sequence state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q  <= '0;
			gathered_q <= '0;
			total_q    <= '0;
		end else if (advance) begin
			pending_q  <= pending_d;
			gathered_q <= gathered_d;
			total_q    <= total_d;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= advance && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			code_point_q <= res_cp;
			seq_length_q <= res_len;
			error_kind_q <= res_err;
		end
	end

	assign out_valid  = out_valid_q;
	assign code_point = code_point_q;
	assign seq_length = seq_length_q;
	assign error_kind = error_kind_q;

endmodule

>>> tb/utf8_decode_checker.sv
`timescale 1ns / 100ps
// Checker for the UTF-8 stream decoder: watches both channels, predicts each result
// from the accepted bytes and compares it with what the block delivers.
// Depends on utf8_pkg.
module utf8_decode_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_stall,
	input  logic [utf8_pkg::BYTE_W-1:0] in_byte,
	input  logic                        out_valid,
	input  logic                        out_stall,
	input  logic [utf8_pkg::CP_W-1:0]   code_point,
	input  logic [utf8_pkg::LEN_W-1:0]  seq_length,
	input  logic [2:0]                  error_kind,
	output int                          mismatch_count,
	output int                          results_due
);
	import utf8_pkg::*;

	// One decoded character or error report.
	typedef struct packed {
		logic [CP_W-1:0]  cp;
		logic [LEN_W-1:0] len;
		utf8_err_t        err;
	} decoded_char_t;

	decoded_char_t char_queue [$];

	// Decoder state as the bytes so far leave it.
	logic [PEND_W-1:0] cont_left;
	logic [CP_W-1:0]   payload_bits;
	logic [LEN_W-1:0]  char_len;

	function automatic void drop_sequence();
		cont_left    = '0;
		payload_bits = '0;
		char_len     = '0;
	endfunction

	// Advances the decoder state by one byte; returns 1 when the byte yields a result.
	function automatic bit decode_byte(input logic [BYTE_W-1:0] b, output decoded_char_t r);
		bit        emits;
		utf8_err_t kind;
		emits = 1'b0;
		r     = '0;
		kind  = ERR_NONE;
		if (cont_left == '0) begin
			// Idle: ASCII completes at once, a lead byte opens a sequence.
			if (b[7] == 1'b0) begin
				r.cp  = {{(CP_W-BYTE_W){1'b0}}, b};
				r.len = 3'd1;
				r.err = ERR_NONE;
				emits = 1'b1;
			end else if (b[7:5] == 3'b110) begin
				payload_bits = {16'd0, b[4:0]};
				cont_left    = 2'd1;
				char_len     = 3'd2;
			end else if (b[7:4] == 4'b1110) begin
				payload_bits = {17'd0, b[3:0]};
				cont_left    = 2'd2;
				char_len     = 3'd3;
			end else if (b[7:3] == 5'b11110) begin
				payload_bits = {18'd0, b[2:0]};
				cont_left    = 2'd3;
				char_len     = 3'd4;
			end else begin
				r.len = 3'd1;
				r.err = ERR_BAD_LEAD;
				emits = 1'b1;
			end
		end else if (b[7:6] != 2'b10) begin
			// A sequence was cut short; the intruding byte is dropped too.
			r.len = char_len - {1'b0, cont_left} + 3'd1;
			r.err = ERR_BAD_CONT;
			emits = 1'b1;
			drop_sequence();
		end else begin
			payload_bits = {payload_bits[CP_W-7:0], b[5:0]};
			cont_left    = cont_left - 2'd1;
			if (cont_left == '0) begin
				// Sequence complete: range checks by length.
				case (char_len)
					3'd2: begin
						if (payload_bits < MIN_TWO_BYTE)
							kind = ERR_OVERLONG;
					end
					3'd3: begin
						if (payload_bits < MIN_THREE_BYTE)
							kind = ERR_OVERLONG;
						else if (payload_bits >= SURR_LOW && payload_bits <= SURR_HIGH)
							kind = ERR_SURROGATE;
					end
					default: begin
						if (payload_bits < MIN_FOUR_BYTE)
							kind = ERR_OVERLONG;
						else if (payload_bits > CP_MAX)
							kind = ERR_ABOVE_MAX;
					end
				endcase
				r.cp  = (kind == ERR_NONE) ? payload_bits : '0;
				r.len = char_len;
				r.err = kind;
				emits = 1'b1;
				drop_sequence();
			end
		end
		return emits;
	endfunction

	initial begin
		mismatch_count = 0;
		results_due    = 0;
	end

	// Compare delivered results first, then predict from the accepted byte.
	always @(posedge clk or negedge arst_n) begin
		decoded_char_t want;
		decoded_char_t next_char;
		if (!arst_n) begin
			drop_sequence();
			char_queue.delete();
			results_due = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (char_queue.size() == 0) begin
					$display("%0t: unexpected result code_point %h seq_length %0d error_kind %0d",
						$time, code_point, seq_length, error_kind);
					mismatch_count = mismatch_count + 1;
				end else begin
					want = char_queue.pop_front();
					if (code_point !== want.cp || seq_length !== want.len
							|| error_kind !== want.err) begin
						$display("%0t: mismatch expected cp %h len %0d err %0d, got cp %h len %0d err %0d",
							$time, want.cp, want.len, want.err,
							code_point, seq_length, error_kind);
						mismatch_count = mismatch_count + 1;
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (decode_byte(in_byte, next_char))
					char_queue.push_back(next_char);
			end
			results_due = char_queue.size();
		end
	end

endmodule

>>> tb/utf8_stream_decoder_top_tb.sv
`timescale 1ns / 100ps
// Testbench top for the UTF-8 stream decoder: drives bytes and output stalls,
// runs the watchdog and prints the verdict. Depends on utf8_pkg and utf8_decode_checker.
module utf8_stream_decoder_top_tb;
	import utf8_pkg::*;

	localparam int QUIET_LIMIT   = 3000;
	localparam int BYTES_PER_RUN = 170;
	localparam int HOLD_CYCLES   = 150;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [BYTE_W-1:0] in_byte;
	logic              out_valid;
	logic              out_stall;
	logic [CP_W-1:0]   code_point;
	logic [LEN_W-1:0]  seq_length;
	logic [2:0]        error_kind;
	int                mismatch_count;
	int                results_due;

	// Idle rates in percent and the current stimulus phase.
	int send_idle_pct;
	int recv_idle_pct;
	int phase;

	logic [BYTE_W-1:0] directed_bytes [$];

	utf8_stream_decoder_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_byte    (in_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.code_point (code_point),
		.seq_length (seq_length),
		.error_kind (error_kind)
	);

	utf8_decode_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_byte        (in_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.code_point     (code_point),
		.seq_length     (seq_length),
		.error_kind     (error_kind),
		.mismatch_count (mismatch_count),
		.results_due    (results_due)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Offers one byte, starting and ending at a falling edge, and waits until it is taken.
	task automatic push_byte(input logic [BYTE_W-1:0] b);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Sends ASCII, noise, or a multi-byte sequence that is sometimes cut short.
	task automatic send_random_char(inout int sent);
		int                pick;
		int                total;
		int                cut;
		int                k;
		logic [BYTE_W-1:0] b;
		pick = int'($urandom_range(0, 99));
		if (pick < 10) begin
			b = BYTE_W'($urandom_range(0, 255));
			push_byte(b);
			sent++;
		end else if (pick < 30) begin
			b = BYTE_W'($urandom_range(0, 127));
			push_byte(b);
			sent++;
		end else begin
			total = int'($urandom_range(2, 4));
			case (total)
				2:       b = 8'hC0 | BYTE_W'($urandom_range(0, 31));
				3:       b = 8'hE0 | BYTE_W'($urandom_range(0, 15));
				default: b = 8'hF0 | BYTE_W'($urandom_range(0, 7));
			endcase
			cut = (pick < 42) ? int'($urandom_range(1, total - 1)) : total;
			push_byte(b);
			sent++;
			for (k = 1; k < cut; k++) begin
				b = 8'h80 | BYTE_W'($urandom_range(0, 63));
				push_byte(b);
				sent++;
			end
			// A byte outside 10xxxxxx breaks the sequence.
			if (cut < total) begin
				b = BYTE_W'($urandom_range(0, 191));
				if (b >= 8'h80)
					b = b + 8'h40;
				push_byte(b);
				sent++;
			end
		end
	endtask

	// Receiver: random stalls, plus one long hold-off when the no-idle phase begins.
	initial begin
		int hold_left;
		bit pressure_done;
		hold_left     = 0;
		pressure_done = 1'b0;
		out_stall <= 1'b0;
		forever begin
			@(negedge clk);
			if (phase == 2 && !pressure_done) begin
				hold_left     = HOLD_CYCLES;
				pressure_done = 1'b1;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
			end
		end
	end

	// Watchdog: ends the run when no item moves on either channel for too long.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("Test completed with failures");
		$finish;
	end

	// Stimulus: reset, directed bytes, then three phases of random characters.
	initial begin
		int sent;
		arst_n        = 1'b0;
		phase         = 0;
		send_idle_pct = 10;
		recv_idle_pct = 87;
		in_valid <= 1'b0;
		in_byte  <= '0;
		directed_bytes = '{
			8'h00, 8'h7F, 8'hFF, 8'h80,        // ASCII extremes, bad leads
			8'hC1, 8'hBF,                      // two-byte overlong
			8'hE0, 8'h9F, 8'hBF,               // three-byte overlong
			8'hED, 8'hA0, 8'h80,               // surrogate
			8'hF0, 8'h8F, 8'hBF, 8'hBF,        // four-byte overlong
			8'hF4, 8'h8F, 8'hBF, 8'hBF,        // largest scalar value
			8'hF5, 8'h80, 8'h80, 8'h80,        // lead above the range
			8'hE2, 8'h41                       // broken continuation
		};
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (directed_bytes[i])
			push_byte(directed_bytes[i]);
		for (int p = 0; p < 3; p++) begin
			phase = p;
			case (p)
				0: begin
					send_idle_pct = 10;
					recv_idle_pct = 87;
				end
				1: begin
					send_idle_pct = 87;
					recv_idle_pct = 10;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			sent = 0;
			while (sent < BYTES_PER_RUN)
				send_random_char(sent);
		end
		in_valid <= 1'b0;
		while (results_due != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
